/* hdl/rpv_pkg.sv */
// rpv_pkg: shared types and constants for the ripng packet validator
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package rpv_pkg;

    localparam logic [3:0] ST_OK          = 4'd0;
    localparam logic [3:0] ST_LENGTH      = 4'd1;
    localparam logic [3:0] ST_NOT_UDP     = 4'd2;
    localparam logic [3:0] ST_PORT        = 4'd3;
    localparam logic [3:0] ST_COMMAND     = 4'd4;
    localparam logic [3:0] ST_VERSION     = 4'd5;
    localparam logic [3:0] ST_ZERO        = 4'd6;
    localparam logic [3:0] ST_METRIC      = 4'd7;
    localparam logic [3:0] ST_PREFIX_LEN  = 4'd8;
    localparam logic [3:0] ST_ROUTE_TAG   = 4'd9;
    localparam logic [3:0] ST_INCONSIST   = 4'd10;

    localparam logic [16:0] POS_MAX       = 17'h1FFFF;
    localparam logic [11:0] COUNT_MAX     = 12'd4095;
    localparam logic [7:0]  NEXT_HOP      = 8'hFF;
    localparam logic [7:0]  PROTO_UDP     = 8'd17;
    localparam logic [7:0]  METRIC_INF    = 8'd16;
    localparam logic [7:0]  ADDR_BITS     = 8'd128;
    localparam logic [15:0] DEFAULT_PORT  = 16'd521;

    // one classified event from the parser: an entry record, a status record or both
    typedef struct packed {
        logic        has_entry;
        logic        has_status;
        logic [7:0]  command;
        logic [63:0] addr_high;
        logic [63:0] addr_low;
        logic [15:0] tag;
        logic [7:0]  plen;
        logic [7:0]  metric;
        logic [3:0]  code;
        logic [11:0] count;
    } rpv_event_t;

    function automatic logic [3:0] ctz8(input logic [7:0] v);
        logic [3:0] n;
        n = 4'd8;
        for (int i = 7; i >= 0; i--) begin
            if (v[i])
            begin
                n = 4'(i);
            end
        end
        return n;
    endfunction

endpackage

/* hdl/rpv_front.sv */
// rpv_front: byte parser, header and entry checks, builds one event per completed entry or packet end
// depends on rpv_pkg
`timescale 1ns / 1ps

module rpv_front
    import rpv_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rip_udp_port_we,
    input  logic [15:0]      rip_udp_port_wdata,
    input  logic             accept,
    input  logic [7:0]       byte_value,
    input  logic             last_byte,
    output logic             ev_push,
    output rpv_event_t       ev_data
);

    logic [15:0] port_reg;
    logic [16:0] pos_reg,   pos_next;
    logic [15:0] plen16_reg, plen16_next;
    logic [7:0]  udp_hi_reg, udp_hi_next;
    logic [7:0]  cmd_reg,   cmd_next;
    logic [3:0]  err_reg,   err_next;
    logic [63:0] addr0_reg, addr0_next;
    logic [63:0] addr1_reg, addr1_next;
    logic [15:0] tag_reg,   tag_next;
    logic [7:0]  eplen_reg, eplen_next;
    logic [7:0]  tz_reg,    tz_next;
    logic [4:0]  off_reg,   off_next;
    logic [11:0] seen_reg,  seen_next;

    logic        in_entry;
    logic        entry_end;
    logic [3:0]  chk;
    logic [15:0] udp_len;
    logic [15:0] udp_rem;
    logic [17:0] len;
    logic        len_bad;

    // multiple-of-20 test: divisible by 4 and by 5 (nibble sum, since 16 = 1 mod 5)
    function automatic logic mult20(input logic [15:0] x);
        logic [5:0] s;
        logic [4:0] t;
        s = 6'(x[3:0]) + 6'(x[7:4]) + 6'(x[11:8]) + 6'(x[15:12]);
        t = 5'(s[5:4]) + 5'(s[3:0]);
        if (t >= 5'd15) t = t - 5'd15;
        if (t >= 5'd10) t = t - 5'd10;
        if (t >= 5'd5)  t = t - 5'd5;
        return (t == 5'd0) && (x[1:0] == 2'b00);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            port_reg <= DEFAULT_PORT;
        end
        else if (rip_udp_port_we)
        begin
            port_reg <= rip_udp_port_wdata;
        end
    end

    assign in_entry  = (pos_reg >= 17'd52) && (pos_reg != POS_MAX);
    assign entry_end = in_entry && (off_reg == 5'd19);
    assign udp_len   = {udp_hi_reg, byte_value};
    assign udp_rem   = udp_len - 16'd12;

    always_comb
    begin
        chk = ST_OK;
        if (byte_value == NEXT_HOP)
        begin
            if (eplen_reg != 8'd0)       chk = ST_PREFIX_LEN;
            else if (tag_reg != 16'd0)   chk = ST_ROUTE_TAG;
        end
        else if (byte_value < 8'd1 || byte_value > METRIC_INF)
        begin
            chk = ST_METRIC;
        end
        else if (eplen_reg > ADDR_BITS)
        begin
            chk = ST_PREFIX_LEN;
        end
        else if (eplen_reg != ADDR_BITS - tz_reg)
        begin
            chk = ST_INCONSIST;
        end
    end

    always_comb
    begin
        pos_next    = (pos_reg != POS_MAX) ? pos_reg + 17'd1 : pos_reg;
        plen16_next = plen16_reg;
        udp_hi_next = udp_hi_reg;
        cmd_next    = cmd_reg;
        err_next    = err_reg;
        addr0_next  = addr0_reg;
        addr1_next  = addr1_reg;
        tag_next    = tag_reg;
        eplen_next  = eplen_reg;
        tz_next     = tz_reg;
        off_next    = off_reg;
        seen_next   = seen_reg;

        if (pos_reg < 17'd52)
        begin
            case (pos_reg[5:0])
                6'd4:  plen16_next = {byte_value, 8'd0};
                6'd5:  plen16_next = {plen16_reg[15:8], byte_value};
                6'd6:  if (byte_value != PROTO_UDP && err_reg == ST_OK) err_next = ST_NOT_UDP;
                6'd40, 6'd42:
                    if (byte_value != port_reg[15:8] && err_reg == ST_OK) err_next = ST_PORT;
                6'd41, 6'd43:
                    if (byte_value != port_reg[7:0] && err_reg == ST_OK) err_next = ST_PORT;
                6'd44: udp_hi_next = byte_value;
                6'd45:
                    if ((udp_len < 16'd12 || !mult20(udp_rem)) && err_reg == ST_OK)
                        err_next = ST_LENGTH;
                6'd48:
                begin
                    cmd_next = byte_value;
                    if (byte_value != 8'd1 && byte_value != 8'd2 && err_reg == ST_OK)
                        err_next = ST_COMMAND;
                end
                6'd49: if (byte_value != 8'd1 && err_reg == ST_OK) err_next = ST_VERSION;
                6'd50, 6'd51: if (byte_value != 8'd0 && err_reg == ST_OK) err_next = ST_ZERO;
                default: ;
            endcase
        end
        else if (in_entry)
        begin
            off_next = (off_reg == 5'd19) ? 5'd0 : off_reg + 5'd1;
            if (off_reg < 5'd8)
            begin
                addr0_next = {addr0_reg[55:0], byte_value};
            end
            else if (off_reg < 5'd16)
            begin
                addr1_next = {addr1_reg[55:0], byte_value};
            end
            else if (off_reg == 5'd16)
            begin
                tag_next = {byte_value, 8'd0};
            end
            else if (off_reg == 5'd17)
            begin
                tag_next = {tag_reg[15:8], byte_value};
            end
            else if (off_reg == 5'd18)
            begin
                eplen_next = byte_value;
            end
            else
            begin
                if (err_reg == ST_OK) err_next = chk;
                if (seen_reg != COUNT_MAX) seen_next = seen_reg + 12'd1;
            end
            // running trailing-zero count over the address bytes
            if (off_reg < 5'd16)
            begin
                if (byte_value != 8'd0)
                    tz_next = 8'(ctz8(byte_value));
                else
                    tz_next = (off_reg == 5'd0) ? 8'd8 : tz_reg + 8'd8;
            end
        end
    end

    assign len     = 18'(pos_reg) + 18'd1;
    assign len_bad = (len < 18'd52) || ((18'(plen16_reg) + 18'd40) != len);

    assign ev_push            = accept && (entry_end || last_byte);
    assign ev_data.has_entry  = entry_end;
    assign ev_data.has_status = last_byte;
    assign ev_data.command    = cmd_next;
    assign ev_data.addr_high  = addr0_reg;
    assign ev_data.addr_low   = addr1_reg;
    assign ev_data.tag        = tag_reg;
    assign ev_data.plen       = eplen_reg;
    assign ev_data.metric     = byte_value;
    assign ev_data.code       = len_bad ? ST_LENGTH : err_next;
    assign ev_data.count      = seen_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            plen16_reg <= '0;
            udp_hi_reg <= '0;
            cmd_reg    <= '0;
            err_reg    <= ST_OK;
            addr0_reg  <= '0;
            addr1_reg  <= '0;
            tag_reg    <= '0;
            eplen_reg  <= '0;
            tz_reg     <= '0;
            off_reg    <= '0;
            seen_reg   <= '0;
        end
        else if (accept)
        begin
            if (last_byte)
            begin
                pos_reg    <= '0;
                plen16_reg <= '0;
                udp_hi_reg <= '0;
                cmd_reg    <= '0;
                err_reg    <= ST_OK;
                addr0_reg  <= '0;
                addr1_reg  <= '0;
                tag_reg    <= '0;
                eplen_reg  <= '0;
                tz_reg     <= '0;
                off_reg    <= '0;
                seen_reg   <= '0;
            end
            else
            begin
                pos_reg    <= pos_next;
                plen16_reg <= plen16_next;
                udp_hi_reg <= udp_hi_next;
                cmd_reg    <= cmd_next;
                err_reg    <= err_next;
                addr0_reg  <= addr0_next;
                addr1_reg  <= addr1_next;
                tag_reg    <= tag_next;
                eplen_reg  <= eplen_next;
                tz_reg     <= tz_next;
                off_reg    <= off_next;
                seen_reg   <= seen_next;
            end
        end
    end

endmodule

/* hdl/rpv_queue.sv */
// rpv_queue: two-deep event queue between parser and output sequencer
// depends on rpv_pkg
`timescale 1ns / 1ps

module rpv_queue
    import rpv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  rpv_event_t  push_data,
    output logic        full,
    input  logic        pop,
    output logic        empty,
    output rpv_event_t  head
);

    rpv_event_t  slot_reg [2];
    logic        wr_reg, wr_next;
    logic        rd_reg, rd_next;
    logic [1:0]  cnt_reg, cnt_next;

    assign full  = (cnt_reg == 2'd2);
    assign empty = (cnt_reg == 2'd0);
    assign head  = slot_reg[rd_reg];

    always_comb
    begin
        wr_next  = push ? ~wr_reg : wr_reg;
        rd_next  = pop ? ~rd_reg : rd_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

/* hdl/rpv_back.sv */
// rpv_back: turns each queued event into one or two result words
// depends on rpv_pkg
`timescale 1ns / 1ps

module rpv_back
    import rpv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        empty,
    input  rpv_event_t  head,
    output logic        pop,
    output logic        result_valid,
    input  logic        result_ready,
    output logic        is_status,
    output logic [7:0]  command,
    output logic [63:0] prefix_high,
    output logic [63:0] prefix_low,
    output logic [15:0] rte_tag,
    output logic [7:0]  prefix_length,
    output logic [7:0]  metric,
    output logic [3:0]  status_code,
    output logic [11:0] entry_count,
    output logic        last_result
);

    // set once the entry word of a two-word event has gone out
    logic phase_reg, phase_next;
    logic fire;

    assign result_valid  = !empty;
    assign fire          = result_valid && result_ready;
    assign is_status     = phase_reg || !head.has_entry;
    assign pop           = fire && (is_status || !head.has_status);
    assign phase_next    = pop ? 1'b0 : (fire ? 1'b1 : phase_reg);

    assign command       = head.command;
    assign prefix_high   = is_status ? 64'd0 : head.addr_high;
    assign prefix_low    = is_status ? 64'd0 : head.addr_low;
    assign rte_tag       = is_status ? 16'd0 : head.tag;
    assign prefix_length = is_status ? 8'd0 : head.plen;
    assign metric        = is_status ? 8'd0 : head.metric;
    assign status_code   = is_status ? head.code : ST_OK;
    assign entry_count   = head.count;
    assign last_result   = is_status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

endmodule

/* hdl/ripng_packet_validator.sv */
// ripng packet validator: one packet byte per cycle in while byte_ready is high, entry and status words out
// each event is registered in the two-deep event queue before its words are presented
// throughput: one byte per cycle while the two-deep event queue has room; a byte that
// ends both an entry and the packet yields two output words, and byte_ready stays
// low while the queue is full
// reset: asynchronous active low, clears parser state and queue, port register to 521
`timescale 1ns / 1ps

module ripng_packet_validator
    import rpv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rip_udp_port_we,
    input  logic [15:0] rip_udp_port_wdata,
    input  logic        byte_valid,
    output logic        byte_ready,
    input  logic [7:0]  byte_value,
    input  logic        last_byte,
    output logic        result_valid,
    input  logic        result_ready,
    output logic        is_status,
    output logic [7:0]  command,
    output logic [63:0] prefix_high,
    output logic [63:0] prefix_low,
    output logic [15:0] rte_tag,
    output logic [7:0]  prefix_length,
    output logic [7:0]  metric,
    output logic [3:0]  status_code,
    output logic [11:0] entry_count,
    output logic        last_result
);

    logic       full, empty, ev_push, pop;
    rpv_event_t ev_data, head;

    assign byte_ready = !full;

    rpv_front u_front (
        .clk                (clk),
        .rst_n              (rst_n),
        .rip_udp_port_we    (rip_udp_port_we),
        .rip_udp_port_wdata (rip_udp_port_wdata),
        .accept             (byte_valid && byte_ready),
        .byte_value         (byte_value),
        .last_byte          (last_byte),
        .ev_push            (ev_push),
        .ev_data            (ev_data)
    );

    rpv_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (ev_push),
        .push_data (ev_data),
        .full      (full),
        .pop       (pop),
        .empty     (empty),
        .head      (head)
    );

    rpv_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .empty         (empty),
        .head          (head),
        .pop           (pop),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .is_status     (is_status),
        .command       (command),
        .prefix_high   (prefix_high),
        .prefix_low    (prefix_low),
        .rte_tag       (rte_tag),
        .prefix_length (prefix_length),
        .metric        (metric),
        .status_code   (status_code),
        .entry_count   (entry_count),
        .last_result   (last_result)
    );

endmodule

/* hdl/rpv_checker.sv */
// rpv_checker: port-level assertions for the ripng packet validator, bound to the top
// depends on rpv_pkg
`timescale 1ns / 1ps

module rpv_checker
    import rpv_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        result_valid,
    input logic        result_ready,
    input logic        is_status,
    input logic [3:0]  status_code,
    input logic [63:0] prefix_high,
    input logic        last_result
);

    a_last_is_status: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (last_result == is_status))
        else $error("last_result differs from is_status");

    a_entry_code_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !is_status) |-> (status_code == ST_OK))
        else $error("entry word carries a status code");

    a_status_no_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && is_status) |-> (prefix_high == 64'd0 && status_code <= ST_INCONSIST))
        else $error("malformed status word");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=> (result_valid && $stable(is_status)))
        else $error("stalled word changed");

endmodule

bind ripng_packet_validator rpv_checker u_rpv_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .is_status    (is_status),
    .status_code  (status_code),
    .prefix_high  (prefix_high),
    .last_result  (last_result)
);

/* verif/ripng_packet_validator_tb.sv */
// testbench for ripng_packet_validator: streams ipv6/udp/ripng packets one byte per word,
// predicts every entry and status word in-house and compares them field by field
// depends on rpv_pkg and the ripng_packet_validator rtl
`timescale 1ns / 1ps

module ripng_packet_validator_tb;
    import rpv_pkg::*;

    typedef struct {
        logic        st;
        logic [7:0]  cmd;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [15:0] tag;
        logic [7:0]  plen;
        logic [7:0]  met;
        logic [3:0]  code;
        logic [11:0] cnt;
        logic        lst;
    } route_rec_t;

    typedef struct {
        logic [7:0] b;
        logic       l;
        logic       typed;
        logic [3:0] code;
    } dir_row_t;

    typedef enum int {
        K_CLEAN, K_NOT_UDP, K_PORT, K_UDP_LEN, K_COMMAND, K_VERSION, K_ZERO,
        K_METRIC, K_PLEN_BIG, K_HOP_TAG, K_HOP_PLEN, K_INCONSIST, K_PAYLOAD_LEN,
        K_TRAILING, K_NOISE, K_NUM
    } flaw_t;

    localparam int ROUTE_ANY = 0;
    localparam int ROUTE_PLAIN = 1;
    localparam int ROUTE_HOP = 2;

    logic        clk;
    logic        rst_n;
    logic        rip_udp_port_we;
    logic [15:0] rip_udp_port_wdata;
    logic        byte_valid;
    logic        byte_ready;
    logic [7:0]  byte_value;
    logic        last_byte;
    logic        result_valid;
    logic        result_ready;
    logic        is_status;
    logic [7:0]  command;
    logic [63:0] prefix_high;
    logic [63:0] prefix_low;
    logic [15:0] rte_tag;
    logic [7:0]  prefix_length;
    logic [7:0]  metric;
    logic [3:0]  status_code;
    logic [11:0] entry_count;
    logic        last_result;

    ripng_packet_validator dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .rip_udp_port_we    (rip_udp_port_we),
        .rip_udp_port_wdata (rip_udp_port_wdata),
        .byte_valid         (byte_valid),
        .byte_ready         (byte_ready),
        .byte_value         (byte_value),
        .last_byte          (last_byte),
        .result_valid       (result_valid),
        .result_ready       (result_ready),
        .is_status          (is_status),
        .command            (command),
        .prefix_high        (prefix_high),
        .prefix_low         (prefix_low),
        .rte_tag            (rte_tag),
        .prefix_length      (prefix_length),
        .metric             (metric),
        .status_code        (status_code),
        .entry_count        (entry_count),
        .last_result        (last_result)
    );

    // parser copy
    logic [15:0] port_reg;
    logic [16:0] pos;
    logic [15:0] pay_len;
    logic [15:0] udp_len;
    logic [7:0]  pkt_cmd;
    logic [3:0]  first_err;
    logic [63:0] addr_acc [2];
    logic [15:0] tag_acc;
    logic [7:0]  plen_acc;
    logic [11:0] seen;

    route_rec_t  pending_words[$];
    int          mismatches;
    bit          fast;
    int          sent_bytes;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("simulation failed");
        $finish;
    end

    task automatic clear_parser();
        pos = '0;
        pay_len = '0;
        udp_len = '0;
        pkt_cmd = '0;
        first_err = ST_OK;
        addr_acc[0] = '0;
        addr_acc[1] = '0;
        tag_acc = '0;
        plen_acc = '0;
        seen = '0;
    endtask

    function automatic int unsigned addr_tz();
        int unsigned n;
        n = 128;
        if (addr_acc[1] != 0)
        begin
            for (int i = 63; i >= 0; i--)
                if (addr_acc[1][i]) n = i;
        end
        else if (addr_acc[0] != 0)
        begin
            for (int i = 63; i >= 0; i--)
                if (addr_acc[0][i]) n = 64 + i;
        end
        return n;
    endfunction

    function automatic logic [3:0] entry_verdict(logic [7:0] m);
        if (m == NEXT_HOP)
        begin
            if (plen_acc != 0) return ST_PREFIX_LEN;
            if (tag_acc != 0) return ST_ROUTE_TAG;
            return ST_OK;
        end
        if (m < 1 || m > METRIC_INF) return ST_METRIC;
        if (plen_acc > ADDR_BITS) return ST_PREFIX_LEN;
        if (int'(plen_acc) != 128 - int'(addr_tz())) return ST_INCONSIST;
        return ST_OK;
    endfunction

    task automatic flag(logic [3:0] c);
        if (first_err == ST_OK) first_err = c;
    endtask

    // expected words for one accepted byte
    task automatic predict_byte(logic [7:0] b, logic l);
        int         p;
        int         off;
        int         len;
        int         cnt;
        route_rec_t r;
        p = int'(pos);
        if (p < 40)
        begin
            if (p == 4) pay_len = {b, 8'h00};
            else if (p == 5) pay_len[7:0] = b;
            else if (p == 6 && b != PROTO_UDP) flag(ST_NOT_UDP);
        end
        else if (p < 52)
        begin
            case (p)
                40, 42: if (b != port_reg[15:8]) flag(ST_PORT);
                41, 43: if (b != port_reg[7:0]) flag(ST_PORT);
                44: udp_len = {b, 8'h00};
                45:
                begin
                    udp_len[7:0] = b;
                    if (udp_len < 12 || (int'(udp_len) - 12) % 20 != 0) flag(ST_LENGTH);
                end
                48:
                begin
                    pkt_cmd = b;
                    if (b != 1 && b != 2) flag(ST_COMMAND);
                end
                49: if (b != 1) flag(ST_VERSION);
                50, 51: if (b != 0) flag(ST_ZERO);
                default: ;
            endcase
        end
        else if (p < int'(POS_MAX))
        begin
            off = (p - 52) % 20;
            if (off < 16) addr_acc[off / 8] = {addr_acc[off / 8][55:0], b};
            else if (off == 16) tag_acc = {b, 8'h00};
            else if (off == 17) tag_acc[7:0] = b;
            else if (off == 18) plen_acc = b;
            else
            begin
                if (first_err == ST_OK) first_err = entry_verdict(b);
                if (seen < COUNT_MAX) seen++;
                r = '{1'b0, pkt_cmd, addr_acc[0], addr_acc[1], tag_acc, plen_acc, b,
                      ST_OK, seen, 1'b0};
                pending_words.push_back(r);
            end
        end
        if (pos < POS_MAX) pos++;
        if (l)
        begin
            len = p + 1;
            r = '{1'b1, pkt_cmd, '0, '0, '0, '0, '0, first_err, '0, 1'b1};
            if (len < 52 || int'(pay_len) + 40 != len) r.code = ST_LENGTH;
            if (len >= 52)
            begin
                cnt = (len - 52) / 20;
                r.cnt = (cnt > int'(COUNT_MAX)) ? COUNT_MAX : 12'(cnt);
            end
            pending_words.push_back(r);
            clear_parser();
        end
    endtask

    task automatic send_byte(logic [7:0] b, logic l);
        int gap;
        gap = fast ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            byte_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_valid <= 1'b1;
        byte_value <= b;
        last_byte <= l;
        do @(posedge clk); while (!byte_ready);
        predict_byte(b, l);
        sent_bytes++;
    endtask

    task automatic drain();
        byte_valid <= 1'b0;
        wait (pending_words.size() == 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_port(logic [15:0] v);
        rip_udp_port_we <= 1'b1;
        rip_udp_port_wdata <= v;
        @(posedge clk);
        port_reg = v;
        rip_udp_port_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic build_packet(flaw_t kind, output logic [7:0] q[$]);
        int           n;
        int           len;
        int           how;
        int           pl;
        int           tz;
        int           s;
        logic [127:0] a;
        q = {};
        if (kind == K_NOISE)
        begin
            n = $urandom_range(1, 70);
            repeat (n) q.push_back(8'($urandom));
            return;
        end
        n = (kind >= K_METRIC && kind <= K_INCONSIST) ? $urandom_range(1, 2)
                                                      : $urandom_range(0, 2);
        len = 52 + 20 * n;
        repeat (40) q.push_back(8'($urandom));
        q[4] = 8'((len - 40) >> 8);
        q[5] = 8'(len - 40);
        q[6] = PROTO_UDP;
        q.push_back(port_reg[15:8]);
        q.push_back(port_reg[7:0]);
        q.push_back(port_reg[15:8]);
        q.push_back(port_reg[7:0]);
        q.push_back(8'((len - 40) >> 8));
        q.push_back(8'(len - 40));
        q.push_back(8'($urandom));
        q.push_back(8'($urandom));
        q.push_back(8'($urandom_range(1, 2)));
        q.push_back(8'd1);
        q.push_back(8'd0);
        q.push_back(8'd0);
        for (int e = 0; e < n; e++)
        begin
            how = ROUTE_ANY;
            if (e == 0 && (kind == K_METRIC || kind == K_PLEN_BIG || kind == K_INCONSIST))
                how = ROUTE_PLAIN;
            if (e == 0 && (kind == K_HOP_TAG || kind == K_HOP_PLEN)) how = ROUTE_HOP;
            if (how == ROUTE_ANY) how = ($urandom_range(0, 3) == 0) ? ROUTE_HOP : ROUTE_PLAIN;
            a = {$urandom, $urandom, $urandom, $urandom};
            if (how == ROUTE_HOP)
            begin
                for (int i = 0; i < 16; i++) q.push_back(a[127 - 8 * i -: 8]);
                q.push_back(8'd0);
                q.push_back(8'd0);
                q.push_back(8'd0);
                q.push_back(NEXT_HOP);
            end
            else
            begin
                s = $urandom_range(0, 3);
                pl = (s == 0) ? 0 : (s == 1) ? 128 : $urandom_range(0, 128);
                if (pl == 0) a = '0;
                else
                begin
                    // lowest set bit sits at 128 minus the prefix length
                    tz = 128 - pl;
                    a = (a >> tz) << tz;
                    a[tz] = 1'b1;
                end
                for (int i = 0; i < 16; i++) q.push_back(a[127 - 8 * i -: 8]);
                q.push_back(8'($urandom));
                q.push_back(8'($urandom));
                q.push_back(8'(pl));
                q.push_back(8'($urandom_range(1, 16)));
            end
        end
        case (kind)
            K_NOT_UDP:     q[6] = 8'($urandom_range(18, 255));
            K_PORT:        q[40 + $urandom_range(0, 3)] ^= 8'(1 << $urandom_range(0, 7));
            K_UDP_LEN:     q[44 + $urandom_range(0, 1)] ^= 8'(1 << $urandom_range(0, 7));
            K_COMMAND:     q[48] = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom_range(3, 255));
            K_VERSION:     q[49] = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom_range(2, 255));
            K_ZERO:        q[50 + $urandom_range(0, 1)] = 8'($urandom_range(1, 255));
            K_METRIC:      q[71] = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom_range(17, 254));
            K_PLEN_BIG:    q[70] = 8'($urandom_range(129, 255));
            K_HOP_TAG:     q[68 + $urandom_range(0, 1)] = 8'($urandom_range(1, 255));
            K_HOP_PLEN:    q[70] = 8'($urandom_range(1, 255));
            K_INCONSIST:   q[70] = (q[70] == 0) ? 8'd1 : q[70] - 8'd1;
            K_PAYLOAD_LEN: q[4 + $urandom_range(0, 1)] ^= 8'(1 << $urandom_range(0, 7));
            K_TRAILING:    repeat ($urandom_range(1, 19)) q.push_back(8'($urandom));
            default: ;
        endcase
    endtask

    task automatic send_packet(logic [7:0] q[$]);
        foreach (q[i]) send_byte(q[i], i == q.size() - 1);
    endtask

    function automatic void cmp(string name, logic [63:0] e, logic [63:0] a);
        if (e !== a)
        begin
            $error("%s: expected %0h, got %0h", name, e, a);
            mismatches++;
        end
    endfunction

    // result side: random stalls, compare each word with the oldest prediction
    initial
    begin
        route_rec_t e;
        int         k;
        result_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            k = fast ? 0 : $urandom_range(0, 13);
            if (k > 0)
            begin
                result_ready <= 1'b0;
                repeat (k) @(posedge clk);
            end
            result_ready <= 1'b1;
            do @(posedge clk); while (!result_valid);
            if (pending_words.size() == 0)
            begin
                $error("unexpected word: is_status %0b status_code %0d", is_status, status_code);
                mismatches++;
            end
            else
            begin
                e = pending_words.pop_front();
                cmp("is_status", e.st, is_status);
                cmp("command", e.cmd, command);
                cmp("prefix_high", e.hi, prefix_high);
                cmp("prefix_low", e.lo, prefix_low);
                cmp("rte_tag", e.tag, rte_tag);
                cmp("prefix_length", e.plen, prefix_length);
                cmp("metric", e.met, metric);
                cmp("status_code", e.code, status_code);
                cmp("entry_count", e.cnt, entry_count);
                cmp("last_result", e.lst, last_result);
            end
        end
    end

    initial
    begin
        dir_row_t    rows [];
        logic [15:0] ports [4];
        logic [7:0]  pkt[$];
        int          idx;
        rows = '{
            '{8'h00, 1'b1, 1'b1, ST_LENGTH},
            '{8'hFF, 1'b1, 1'b1, ST_LENGTH},
            '{8'h60, 1'b0, 1'b0, ST_OK},
            '{8'h00, 1'b0, 1'b0, ST_OK},
            '{8'h00, 1'b0, 1'b0, ST_OK},
            '{8'h00, 1'b0, 1'b0, ST_OK},
            '{8'h00, 1'b0, 1'b0, ST_OK},
            '{8'h0C, 1'b0, 1'b0, ST_OK},
            '{8'h11, 1'b1, 1'b1, ST_LENGTH}
        };
        ports = '{16'd0, 16'hFFFF, DEFAULT_PORT, 16'h0000};
        rst_n = 1'b0;
        rip_udp_port_we = 1'b0;
        rip_udp_port_wdata = '0;
        byte_valid = 1'b0;
        byte_value = '0;
        last_byte = 1'b0;
        mismatches = 0;
        sent_bytes = 0;
        fast = 1'b0;
        port_reg = DEFAULT_PORT;
        clear_parser();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // short packets, all length errors
        foreach (rows[i])
        begin
            send_byte(rows[i].b, rows[i].l);
            if (rows[i].typed)
            begin
                pending_words[$].code = rows[i].code;
                pending_words[$].cnt = '0;
            end
        end

        ports[3] = 16'($urandom);
        idx = 0;
        for (int ph = 0; ph < 4; ph++)
        begin
            drain();
            write_port(ports[ph]);
            fast = (ph == 2);
            while (sent_bytes < 170 * (ph + 1) || idx < int'(K_NUM) * (ph + 1) / 4 + 1)
            begin
                build_packet(flaw_t'(idx < int'(K_NUM) ? idx % int'(K_NUM)
                                                         : $urandom_range(0, K_NUM - 1)), pkt);
                send_packet(pkt);
                idx++;
            end
        end

        byte_valid <= 1'b0;
        wait (pending_words.size() == 0);
        repeat (20) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

/* files.f */
hdl/rpv_pkg.sv
hdl/rpv_front.sv
hdl/rpv_queue.sv
hdl/rpv_back.sv
hdl/ripng_packet_validator.sv
hdl/rpv_checker.sv
verif/ripng_packet_validator_tb.sv
